// ----- rtl/modular_exponentiation_defines.svh -----
// Assertion macros used by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mexp_pkg.sv -----
`default_nettype none

package mexp_pkg;

   typedef logic [2:0] state_type;

   localparam state_type ST_IDLE   = 3'd0;
   localparam state_type ST_REDUCE = 3'd1;
   localparam state_type ST_MULT   = 3'd2;
   localparam state_type ST_SQUARE = 3'd3;
   localparam state_type ST_FINISH = 3'd4;

   typedef logic [0:0] reg_index_type;

   localparam reg_index_type REG_MODULUS  = 1'b0;
   localparam reg_index_type REG_EXPONENT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/modular_exponentiation.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_block_value
// rsp       out        rsp_valid/rsp_ready    rsp_power_result
// csr       in/out     APB-style, pready=1    modulus (index 0), exponent (index 1)
//
// Each word is first reduced by the modulus and then takes M modular multiplications
// (ones in the exponent plus its bit length less one, none for a zero exponent),
// each stepping through all W multiplier bits, W being OPERAND_WIDTH; a zero
// modulus goes straight to the final state and answers zero.
// The single shift-add-reduce step unit handles one multiplier bit per cycle.
// Reset clears the control state and sets modulus to 1 and exponent to 0.
// A new word is taken only when the sequencer is idle; a stalled result holds
// the sequencer in its final state until the output register is free.
`default_nettype none

module modular_exponentiation #(
   parameter int OPERAND_WIDTH = 32,
   localparam int CSR_WIDTH  = (OPERAND_WIDTH > 32) ? 64 : 32,
   localparam int ADDR_WIDTH = (OPERAND_WIDTH > 32) ? 4 : 3
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [OPERAND_WIDTH-1:0] req_block_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [OPERAND_WIDTH-1:0]      rsp_power_result,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [CSR_WIDTH-1:0]     csr_pwdata,
   output logic [CSR_WIDTH-1:0]          csr_prdata,
   output logic                          csr_pready
);

   import mexp_pkg::*;

`include "modular_exponentiation_defines.svh"

   localparam int W          = OPERAND_WIDTH;
   localparam int SW         = OPERAND_WIDTH + 2;
   localparam int CNT_WIDTH  = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(OPERAND_WIDTH - 1);

   // Configuration registers.
   logic [W-1:0] modulus_ff, modulus_in;
   logic [W-1:0] exponent_ff, exponent_in;
   reg_index_type csr_index;
   logic          csr_write;

   // Sequencer and datapath registers.
   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic [W-1:0]          prod_ff, prod_in;
   logic [W-1:0]          shreg_ff, shreg_in;
   logic [W-1:0]          base_ff, base_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic [W-1:0]          exp_ff, exp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]          result_ff, result_in;

   // Step unit signals.
   logic [W-1:0]  addend;
   logic [SW-1:0] step_sum;
   logic [SW-1:0] step_less_n;
   logic [SW-1:0] step_less_2n;
   logic [W-1:0]  step_result;

   logic [W-1:0]  disp_exp;
   logic [W-1:0]  disp_base;
   logic          req_accept;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[ADDR_WIDTH-1];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MODULUS:  modulus_in  = csr_pwdata[W-1:0];
            REG_EXPONENT: exponent_in = csr_pwdata[W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_MODULUS:  csr_prdata[W-1:0] = modulus_ff;
         REG_EXPONENT: csr_prdata[W-1:0] = exponent_ff;
         default:      csr_prdata = '0;
      endcase
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign req_accept       = req_valid & req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = result_ff;

   // One multiplier bit per cycle: 2*prod + bit*addend, brought below the
   // modulus by subtracting it at most twice, as the sum stays below three times it.
   assign addend       = (state_ff == ST_REDUCE) ? {{(W-1){1'b0}}, 1'b1} : base_ff;
   assign step_sum     = {1'b0, prod_ff, 1'b0} + (shreg_ff[W-1] ? {2'b00, addend} : '0);
   assign step_less_n  = step_sum - {2'b00, modulus_ff};
   assign step_less_2n = step_sum - {1'b0, modulus_ff, 1'b0};

   always_comb begin
      if (!step_less_2n[SW-1]) begin
         step_result = step_less_2n[W-1:0];
      end else if (!step_less_n[SW-1]) begin
         step_result = step_less_n[W-1:0];
      end else begin
         step_result = step_sum[W-1:0];
      end
   end

   // After a multiplication the exponent bit just used is cleared, so the
   // next step is always a squaring unless nothing of the exponent remains.
   assign disp_exp  = (state_ff == ST_MULT) ? {exp_ff[W-1:1], 1'b0} : exp_ff;
   assign disp_base = (state_ff == ST_MULT) ? base_ff : step_result;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      shreg_in     = shreg_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      result_in    = result_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               count_in = '0;
               prod_in  = '0;
               shreg_in = req_block_value;
               exp_in   = exponent_ff;
               acc_in   = {{(W-1){1'b0}}, 1'b1};
               if (modulus_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE, ST_MULT, ST_SQUARE: begin
            prod_in  = step_result;
            shreg_in = {shreg_ff[W-2:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               count_in = '0;
               prod_in  = '0;
               if (state_ff == ST_MULT) begin
                  acc_in = step_result;
               end else begin
                  base_in = step_result;
               end
               if (disp_exp == '0) begin
                  exp_in   = disp_exp;
                  state_in = ST_FINISH;
               end else if (disp_exp[0]) begin
                  exp_in   = disp_exp;
                  shreg_in = acc_ff;
                  state_in = ST_MULT;
               end else begin
                  exp_in   = {1'b0, disp_exp[W-1:1]};
                  shreg_in = disp_base;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               result_in    = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= {{(W-1){1'b0}}, 1'b1};
         exponent_ff  <= '0;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      shreg_ff  <= shreg_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      exp_ff    <= exp_in;
      result_ff <= result_in;
   end

   `MEXP_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE,
      "accepted word did not start the sequencer")
   `MEXP_ASSERT_SAME(a_idle_count_clear, clock, reset, state_ff == ST_IDLE, count_ff == '0,
      "bit counter not clear while idle")
   `MEXP_ASSERT_SAME(a_prod_reduced, clock, reset,
      (state_ff == ST_REDUCE) || (state_ff == ST_MULT) || (state_ff == ST_SQUARE),
      prod_ff < modulus_ff, "running remainder not below the modulus")
   `MEXP_ASSERT_SAME(a_base_reduced, clock, reset,
      (state_ff == ST_MULT) || (state_ff == ST_SQUARE),
      base_ff < modulus_ff, "base not below the modulus")
   `MEXP_ASSERT_NEXT(a_zero_modulus, clock, reset, req_accept && (modulus_ff == '0),
      (state_ff == ST_FINISH) && (acc_ff == '0), "zero modulus must answer zero at once")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import mexp_pkg::*;

   localparam int WIDTH = 32;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int WORD_LATENCY = 2 + WIDTH * 64;

   typedef enum {NO_IDLE, SENDER_IDLE, RECEIVER_IDLE, BOTH_IDLE} idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [WIDTH-1:0] req_block_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [WIDTH-1:0] rsp_power_result;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic [WIDTH-1:0] key_modulus = 1;
   logic [WIDTH-1:0] key_exponent = 0;
   logic [WIDTH-1:0] pending_powers[$];
   idle_mode_type idle_mode = NO_IDLE;
   int hold_cycles = 0;
   int mismatches = 0;
   int cycle_count = 0;

   modular_exponentiation #(.OPERAND_WIDTH(WIDTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_block_value(req_block_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power_result(rsp_power_result),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic logic [WIDTH-1:0] product_mod(input logic [WIDTH-1:0] a,
                                                    input logic [WIDTH-1:0] b,
                                                    input logic [WIDTH-1:0] n);
      logic [2*WIDTH-1:0] full;
      full = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
      return WIDTH'(full % {{WIDTH{1'b0}}, n});
   endfunction

   // Right-to-left square and multiply; the accumulator starts at one and is
   // only reduced once a set exponent bit multiplies into it.
   function automatic logic [WIDTH-1:0] expected_power(input logic [WIDTH-1:0] block);
      logic [WIDTH-1:0] square;
      logic [WIDTH-1:0] acc;
      logic [WIDTH-1:0] bits;
      if (key_modulus == 0)
         return '0;
      square = block % key_modulus;
      acc = 1;
      bits = key_exponent;
      while (bits != 0) begin
         if (bits[0])
            acc = product_mod(acc, square, key_modulus);
         bits = bits >> 1;
         if (bits != 0)
            square = product_mod(square, square, key_modulus);
      end
      return acc;
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         SENDER_IDLE: return $urandom_range(99) < 84;
         BOTH_IDLE:   return $urandom_range(99) < 19;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         RECEIVER_IDLE: return $urandom_range(99) < 84;
         BOTH_IDLE:     return $urandom_range(99) < 19;
         default:       return 1'b0;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL modular_exponentiation");
         $finish;
      end
   end

   // A long hold takes precedence over the random stalls of the current phase.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= !receiver_stalls();
      end
   end

   always @(posedge clock) begin : check_results
      logic [WIDTH-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_powers.size() == 0) begin
            note_mismatch("result word with nothing outstanding", '0, rsp_power_result);
         end else begin
            want = pending_powers.pop_front();
            if (rsp_power_result !== want)
               note_mismatch("power_result mismatch", want, rsp_power_result);
         end
      end
   end

   task automatic send_block(input logic [WIDTH-1:0] value);
      if (sender_idles()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (sender_idles());
      end
      req_valid <= 1'b1;
      req_block_value <= value;
      do @(posedge clock); while (!req_ready);
      pending_powers = {pending_powers, expected_power(value)};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_powers.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_read(input reg_index_type index, input logic [31:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         note_mismatch("register read-back mismatch", want, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_MODULUS)
         key_modulus = value;
      else
         key_exponent = value;
      csr_read(index, value);
   endtask

   task automatic set_key(input logic [WIDTH-1:0] modulus, input logic [WIDTH-1:0] exponent);
      drain();
      csr_write(REG_MODULUS, modulus);
      csr_write(REG_EXPONENT, exponent);
   endtask

   function automatic logic [WIDTH-1:0] random_modulus();
      case ($urandom_range(9))
         0:       return '1;
         1:       return 1;
         2:       return $urandom_range(2, 255);
         3:       return 32'h8000_0000 | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // Exponents of every bit length, so that word times vary widely.
   function automatic logic [WIDTH-1:0] random_exponent();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(1, 16);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [WIDTH-1:0] random_block();
      case ($urandom_range(5))
         0:       return key_modulus - 1;
         1:       return $urandom & 32'hFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_reset_values();
      csr_read(REG_MODULUS, 1);
      csr_read(REG_EXPONENT, 0);
      send_block('0);
      send_block('1);
   endtask

   task automatic test_directed_corners();
      set_key('1, '1);
      send_block('0);
      send_block(1);
      send_block('1);
      send_block(32'hFFFF_FFFE);
      set_key(3233, 17);
      send_block(65);
      send_block(3232);
      send_block(3233 + 65);
      set_key(3233, 2753);
      send_block(2790);
      // A modulus of one gives zero unless the exponent is zero.
      set_key(1, 7);
      send_block(12345);
      set_key(1, 0);
      send_block('1);
      // A zero modulus answers zero whatever the exponent.
      set_key(0, 0);
      send_block(5);
      set_key(0, '1);
      send_block('1);
      set_key(32'h8000_0000, 32'h8000_0000);
      send_block(3);
      send_block('1);
      set_key(32'hFFFF_FFFB, 1);
      send_block('1);
      set_key(32'hFFFF_FFFB, 2);
      send_block(32'hFFFF_FFFA);
   endtask

   task automatic test_random_phases();
      idle_mode_type modes[4];
      modes = '{NO_IDLE, SENDER_IDLE, RECEIVER_IDLE, BOTH_IDLE};
      foreach (modes[m]) begin
         idle_mode = modes[m];
         repeat (5) begin
            set_key(random_modulus(), random_exponent());
            repeat (14) send_block(random_block());
         end
      end
   endtask

   // The result channel is held off while words keep coming, so the block
   // fills and must refuse further input until the hold is over.
   task automatic test_input_backpressure();
      idle_mode = NO_IDLE;
      set_key($urandom | 32'h1000_0000, 5);
      hold_cycles = 800;
      repeat (8) send_block($urandom);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_corners();
      test_random_phases();
      test_input_backpressure();
      drain();
      repeat (WORD_LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("PASS modular_exponentiation");
      else
         $display("FAIL modular_exponentiation");
      $finish;
   end

endmodule

`default_nettype wire

// ----- modular_exponentiation.f -----
+incdir+rtl
rtl/mexp_pkg.sv
rtl/modular_exponentiation.sv
verif/tb.sv
